[sv/peg_pkg.sv]
// Shared widths, register indexes and reset values of the Prewitt gradient block.
`default_nettype none
package peg_pkg;

  // Pixel and result field widths
  localparam int PIX_W      = 8;
  localparam int ROW_W      = 12;
  localparam int OUT_COL_W  = 10;
  localparam int GRAD_W     = 11;
  localparam int ABS_W      = 8;
  localparam int ROOT_W     = 11;
  localparam int SUM_W      = 2 * ROOT_W - 1;
  localparam int SQ_W       = SUM_W - 1;
  localparam int TDATA_W    = 72;
  localparam int LINE_W     = 2 * PIX_W;

  // Configuration port
  localparam int CFG_WIDTH_W  = 11;
  localparam int CFG_HEIGHT_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_INDEX_W  = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam int DEFAULT_MAX_WIDTH = 1024;
  localparam int MAX_HEIGHT        = 4096;
  localparam int MIN_DIM           = 3;

  localparam logic [CFG_WIDTH_W-1:0]  RESET_WIDTH  = 11'd1024;
  localparam logic [CFG_HEIGHT_W-1:0] RESET_HEIGHT = 13'd1024;

  // Saturation limit of the absolute gradients
  localparam logic [ABS_W-1:0] ABS_MAX = 8'd255;

endpackage
`default_nettype wire

[sv/prewitt_edge_gradient.sv]
// Top level: line store, 3x3 window, gradient datapath and result sequencer.
//
// Usage: grey pixels enter on the s_* stream in raster order, one per item.
// Results leave on the m_* stream; each carries row, column, both Prewitt
// gradients, their saturated absolute values and the rounded magnitude.
// m_tlast marks the final result caused by one pixel (0, 1, 2 or 4 results).
// Borders use reflect-101 mirroring; row 0 gives no result and the last
// row is finished as its pixels arrive.
// Both line stores sit in one RAM, 16 bits per column, read at the column
// on accept and written back in the read state that follows, before the next read.
// Each pixel passes the idle and read states; each result then adds the
// gradient, square, square-root start, a wait on the shared square-root
// unit and the output load.
// A finished result waits in the output register while the next pixel is
// accepted; a stalled receiver holds the sequencer only when the next
// result is ready to load. Reset clears counters and handshakes and sets
// width and height to 1024; a configuration write restarts the frame.
`default_nettype none
module prewitt_edge_gradient
  import peg_pkg::*;
#(
  parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  // Configuration write port
  input  wire logic                    cfg_we,
  input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data,
  // Pixel stream
  input  wire logic                    s_tvalid,
  output logic                         s_tready,
  input  wire logic [PIX_W-1:0]        s_tdata,   // [7:0] pixel
  // Result stream
  output logic                         m_tvalid,
  input  wire logic                    m_tready,
  // [11:0] out_row, [21:12] out_col, [32:22] gradient_x, [43:33] gradient_y,
  // [51:44] abs_x, [59:52] abs_y, [70:60] magnitude, [71] zero
  output logic      [TDATA_W-1:0]      m_tdata,
  output logic                         m_tlast    // last_of_run
);

  localparam int CNT_W = $clog2(MAX_WIDTH);
  localparam int WID_W = ($clog2(MAX_WIDTH + 1) > CFG_WIDTH_W) ?
                         $clog2(MAX_WIDTH + 1) : CFG_WIDTH_W;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_READ = 7'b0000010,
    S_GRAD = 7'b0000100,
    S_SQR  = 7'b0001000,
    S_LOAD = 7'b0010000,
    S_ROOT = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state;

  logic [CFG_WIDTH_W-1:0]  cfg_width;
  logic [CFG_HEIGHT_W-1:0] cfg_height;
  logic [WID_W-1:0]        eff_width;
  logic [CFG_HEIGHT_W-1:0] eff_height;
  logic [CNT_W-1:0]        last_col;
  logic [ROW_W-1:0]        last_row;

  logic [ROW_W-1:0]  row_cnt;
  logic [CNT_W-1:0]  col_cnt;
  logic [ROW_W-1:0]  row_q;
  logic [CNT_W-1:0]  col_q;
  logic [PIX_W-1:0]  pix_q;

  logic [LINE_W-1:0] line_rdata;
  logic              line_we;

  logic [PIX_W-1:0]  win [3][3];

  logic              at_last_row;
  logic              at_last_col;
  logic              emit_any;
  logic              top_dup;
  logic              left_dup;

  logic [1:0]        vsel;
  logic [1:0]        nxt_v;
  logic              nxt_found;

  logic [PIX_W-1:0]  tp [3];
  logic [PIX_W-1:0]  mp [3];
  logic [PIX_W-1:0]  bp [3];
  logic [PIX_W-1:0]  tl, tc, tr, ml, mr, bl, bc, br;
  logic [GRAD_W-1:0] gx_c, gy_c;

  logic signed [GRAD_W-1:0]   gx, gy;
  logic signed [2*GRAD_W-1:0] prod_x, prod_y;
  logic [SQ_W-1:0]            sq_x, sq_y;
  logic [SUM_W-1:0]           sum_sq;

  logic              sqrt_start;
  logic              root_done;
  logic [ROOT_W-1:0] root;

  logic [GRAD_W-1:0] abs_gx, abs_gy;
  logic [ABS_W-1:0]  sat_x, sat_y;
  logic [ROW_W-1:0]  res_row;
  logic [OUT_COL_W-1:0] res_col;
  logic              out_free;

  function automatic logic var_en(logic [1:0] v, logic lr, logic lc);
    var_en = (!v[0] || lr) && (!v[1] || lc);
  endfunction

  // Clamp the configured frame size to the supported range
  always_comb begin
    if (WID_W'(cfg_width) < WID_W'(MIN_DIM)) begin
      eff_width = WID_W'(MIN_DIM);
    end else if (WID_W'(cfg_width) > WID_W'(MAX_WIDTH)) begin
      eff_width = WID_W'(MAX_WIDTH);
    end else begin
      eff_width = WID_W'(cfg_width);
    end
    if (cfg_height < CFG_HEIGHT_W'(MIN_DIM)) begin
      eff_height = CFG_HEIGHT_W'(MIN_DIM);
    end else if (cfg_height > CFG_HEIGHT_W'(MAX_HEIGHT)) begin
      eff_height = CFG_HEIGHT_W'(MAX_HEIGHT);
    end else begin
      eff_height = cfg_height;
    end
  end

  assign last_col = CNT_W'(eff_width - WID_W'(1));
  assign last_row = ROW_W'(eff_height - CFG_HEIGHT_W'(1));

  // Position flags of the pixel in work
  assign at_last_row = (row_q == last_row);
  assign at_last_col = (col_q == last_col);
  assign emit_any    = (row_q != '0) && (col_q != '0);
  assign top_dup     = (row_q == ROW_W'(1));
  assign left_dup    = (col_q == CNT_W'(1));

  assign s_tready   = (state == S_IDLE);
  assign line_we    = (state == S_READ);
  assign sqrt_start = (state == S_LOAD);
  assign out_free   = !m_tvalid || m_tready;

  // Both line stores: upper in the high byte, middle in the low byte
  peg_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (line_we),
    .waddr (col_q),
    .wdata ({line_rdata[PIX_W-1:0], pix_q}),
    .raddr (col_cnt),
    .rdata (line_rdata)
  );

  // Configuration registers and frame counters
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= RESET_WIDTH;
      cfg_height <= RESET_HEIGHT;
      row_cnt    <= '0;
      col_cnt    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  cfg_width  <= cfg_data[CFG_WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: cfg_height <= cfg_data[CFG_HEIGHT_W-1:0];
        default: ;
      endcase
      row_cnt <= '0;
      col_cnt <= '0;
    end else if (state == S_READ) begin
      if (at_last_col) begin
        col_cnt <= '0;
        row_cnt <= at_last_row ? '0 : row_q + ROW_W'(1);
      end else begin
        col_cnt <= col_q + CNT_W'(1);
      end
    end
  end

  // Shift the window and load the new column from the line stores
  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      for (int i = 0; i < 3; i++) begin
        win[i][0] <= win[i][1];
        win[i][1] <= win[i][2];
      end
      win[0][2] <= line_rdata[LINE_W-1:PIX_W];
      win[1][2] <= line_rdata[PIX_W-1:0];
      win[2][2] <= pix_q;
    end
  end

  // Pick mirrored rows and columns for the current result
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      tp[j] = vsel[0] ? win[1][j] : (top_dup ? win[2][j] : win[0][j]);
      mp[j] = vsel[0] ? win[2][j] : win[1][j];
      bp[j] = vsel[0] ? win[1][j] : win[2][j];
    end
    tl = vsel[1] ? tp[1] : (left_dup ? tp[2] : tp[0]);
    ml = vsel[1] ? mp[1] : (left_dup ? mp[2] : mp[0]);
    bl = vsel[1] ? bp[1] : (left_dup ? bp[2] : bp[0]);
    tc = vsel[1] ? tp[2] : tp[1];
    bc = vsel[1] ? bp[2] : bp[1];
    tr = vsel[1] ? tp[1] : tp[2];
    mr = vsel[1] ? mp[1] : mp[2];
    br = vsel[1] ? bp[1] : bp[2];
    gx_c = (GRAD_W'(tr) + GRAD_W'(mr) + GRAD_W'(br))
         - (GRAD_W'(tl) + GRAD_W'(ml) + GRAD_W'(bl));
    gy_c = (GRAD_W'(bl) + GRAD_W'(bc) + GRAD_W'(br))
         - (GRAD_W'(tl) + GRAD_W'(tc) + GRAD_W'(tr));
  end

  // Find the next result of this pixel, in output order
  always_comb begin
    nxt_found = 1'b0;
    nxt_v     = vsel;
    for (int v = 3; v >= 1; v--) begin
      if ((2'(v) > vsel) && var_en(2'(v), at_last_row, at_last_col)) begin
        nxt_found = 1'b1;
        nxt_v     = 2'(v);
      end
    end
  end

  // Gradient registers and squares
  assign prod_x = gx * gx;
  assign prod_y = gy * gy;
  assign sum_sq = SUM_W'(sq_x) + SUM_W'(sq_y);

  always_ff @(posedge clk) begin
    if (state == S_GRAD) begin
      gx <= gx_c;
      gy <= gy_c;
    end
    if (state == S_SQR) begin
      sq_x <= prod_x[SQ_W-1:0];
      sq_y <= prod_y[SQ_W-1:0];
    end
  end

  peg_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (sum_sq),
    .done     (root_done),
    .root     (root)
  );

  // Saturated absolute values and result position
  always_comb begin
    abs_gx  = gx[GRAD_W-1] ? GRAD_W'(-gx) : gx;
    abs_gy  = gy[GRAD_W-1] ? GRAD_W'(-gy) : gy;
    sat_x   = (abs_gx > GRAD_W'(ABS_MAX)) ? ABS_MAX : abs_gx[ABS_W-1:0];
    sat_y   = (abs_gy > GRAD_W'(ABS_MAX)) ? ABS_MAX : abs_gy[ABS_W-1:0];
    res_row = vsel[0] ? row_q : row_q - ROW_W'(1);
    res_col = vsel[1] ? OUT_COL_W'(col_q) : OUT_COL_W'(col_q - CNT_W'(1));
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      vsel  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          vsel  <= '0;
          state <= emit_any ? S_GRAD : S_IDLE;
        end
        S_GRAD: state <= S_SQR;
        S_SQR:  state <= S_LOAD;
        S_LOAD: state <= S_ROOT;
        S_ROOT: begin
          if (root_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            if (nxt_found) begin
              vsel  <= nxt_v;
              state <= S_GRAD;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Capture the accepted pixel and its position
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      pix_q <= s_tdata;
      row_q <= row_cnt;
      col_q <= col_cnt;
    end
  end

  // Output register: load a result when free, drop valid when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      m_tdata <= {1'b0, root, sat_y, sat_x, gy, gx, res_col, res_row};
      m_tlast <= !nxt_found;
    end
  end

  // Square root completes only while the sequencer waits for it
  a_root_in_wait: assert property (@(posedge clk) disable iff (rst)
    root_done |-> state == S_ROOT)
    else $error("square root finished outside its wait state");

  // Every result the sequencer computes is one the pixel position calls for
  a_var_enabled: assert property (@(posedge clk) disable iff (rst)
    state == S_GRAD |-> emit_any && var_en(vsel, at_last_row, at_last_col))
    else $error("result variant computed that the position does not allow");

  // Frame counters stay inside the configured frame
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (col_cnt <= last_col) && (row_cnt <= last_row))
    else $error("frame counter beyond configured size");

  // An accepted pixel goes straight to the line store access
  a_accept_read: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !cfg_we |=> state == S_READ)
    else $error("accepted pixel did not start a line store access");

endmodule
`default_nettype wire

[sv/peg_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module peg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable, read every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[sv/peg_isqrt.sv]
// Bit-pair integer square root, one result bit per cycle, rounded to nearest.
`default_nettype none
module peg_isqrt
  import peg_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [SUM_W-1:0]  radicand,
  output logic                   done,
  output logic      [ROOT_W-1:0] root
);

  logic              busy;
  logic [SUM_W-1:0]  rem;
  logic [SUM_W:0]    acc;
  logic [SUM_W-1:0]  bitpos;
  logic [SUM_W:0]    trial;
  logic              fits;
  logic              round_up;

  assign trial    = acc + {1'b0, bitpos};
  assign fits     = {1'b0, rem} >= trial;
  assign round_up = {1'b0, rem} > acc;

  // Control: busy while bit position is nonzero, pulse done after rounding
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && bitpos == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath: one trial subtraction per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem    <= radicand;
      acc    <= '0;
      bitpos <= SUM_W'(1) << (2 * (ROOT_W - 1));
    end else if (busy) begin
      if (bitpos != '0) begin
        if (fits) begin
          rem <= rem - trial[SUM_W-1:0];
          acc <= (acc >> 1) + {1'b0, bitpos};
        end else begin
          acc <= acc >> 1;
        end
        bitpos <= bitpos >> 2;
      end else begin
        root <= acc[ROOT_W-1:0] + ROOT_W'(round_up);
      end
    end
  end

endmodule
`default_nettype wire

[dv/peg_gradient_checker.sv]
// Checker for the Prewitt gradient block: tracks the pixel stream, predicts and compares results.
`default_nettype none
module peg_gradient_checker
  import peg_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   s_tvalid,
  input  wire logic                   s_tready,
  input  wire logic [PIX_W-1:0]       s_tdata,
  input  wire logic                   m_tvalid,
  input  wire logic                   m_tready,
  input  wire logic [TDATA_W-1:0]     m_tdata,
  input  wire logic                   m_tlast,
  output int                          outstanding,
  output int                          fail_count
);

  typedef struct packed {
    logic [ROW_W-1:0]     row;
    logic [OUT_COL_W-1:0] col;
    logic [GRAD_W-1:0]    gx;
    logic [GRAD_W-1:0]    gy;
    logic [ABS_W-1:0]     ax;
    logic [ABS_W-1:0]     ay;
    logic [ROOT_W-1:0]    mag;
    logic                 last;
  } gradient_t;

  // Shadow copy of the line stores, window, raster position and frame size
  logic [PIX_W-1:0]        upper_row  [DEFAULT_MAX_WIDTH];
  logic [PIX_W-1:0]        middle_row [DEFAULT_MAX_WIDTH];
  logic [PIX_W-1:0]        win [3][3];
  int unsigned             cur_row;
  int unsigned             cur_col;
  logic [CFG_WIDTH_W-1:0]  width_reg;
  logic [CFG_HEIGHT_W-1:0] height_reg;
  gradient_t               expected_gradients[$];
  int                      mismatches;

  initial begin
    outstanding = 0;
    fail_count  = 0;
    mismatches  = 0;
  end

  // Square root rounded to nearest: floor root, then bump when the remainder exceeds it
  function automatic int unsigned round_root(input int unsigned n);
    int unsigned s;
    s = 0;
    while ((s + 1) * (s + 1) <= n) s++;
    if (n - s * s > s) s++;
    return s;
  endfunction

  function automatic logic [ABS_W-1:0] clip_abs(input int g);
    int a;
    a = (g < 0) ? -g : g;
    return (a > int'(ABS_MAX)) ? ABS_MAX : a[ABS_W-1:0];
  endfunction

  // Gradients over the window with the given row and column roles (mirrored at borders)
  function automatic gradient_t window_gradient(input int row, input int col,
                                                input int t, input int m, input int b,
                                                input int l, input int ce, input int r);
    int        rs[3];
    int        cs[3];
    int        gx;
    int        gy;
    int        i;
    int        root;
    gradient_t g;
    rs[0] = t;
    rs[1] = m;
    rs[2] = b;
    cs[0] = l;
    cs[1] = ce;
    cs[2] = r;
    gx = 0;
    gy = 0;
    for (i = 0; i < 3; i++) begin
      gx += int'(win[rs[i]][r]) - int'(win[rs[i]][l]);
      gy += int'(win[b][cs[i]]) - int'(win[t][cs[i]]);
    end
    root   = round_root(gx * gx + gy * gy);
    g.row  = row[ROW_W-1:0];
    g.col  = col[OUT_COL_W-1:0];
    g.gx   = gx[GRAD_W-1:0];
    g.gy   = gy[GRAD_W-1:0];
    g.ax   = clip_abs(gx);
    g.ay   = clip_abs(gy);
    g.mag  = root[ROOT_W-1:0];
    g.last = 1'b0;
    return g;
  endfunction

  function automatic string describe(input gradient_t g);
    return $sformatf("row %0d col %0d gx %0d gy %0d |gx| %0d |gy| %0d mag %0d last %0b",
                     g.row, g.col, $signed(g.gx), $signed(g.gy), g.ax, g.ay, g.mag, g.last);
  endfunction

  // Advance the window by one pixel and queue the results it completes
  task automatic take_pixel(input logic [PIX_W-1:0] px);
    int unsigned w;
    int unsigned h;
    int unsigned r;
    int unsigned c;
    bit          on_last_row;
    int          t;
    int          l;
    int          i;
    gradient_t   batch[$];
    gradient_t   g;
    w = (width_reg < MIN_DIM) ? MIN_DIM :
        (width_reg > DEFAULT_MAX_WIDTH) ? DEFAULT_MAX_WIDTH : width_reg;
    h = (height_reg < MIN_DIM) ? MIN_DIM :
        (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
    r = cur_row;
    c = cur_col;
    if (c >= w) c = 0;
    if (r >= h) r = 0;
    on_last_row = (r == h - 1);

    for (i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = upper_row[c];
    win[1][2] = middle_row[c];
    win[2][2] = px;
    upper_row[c]  = middle_row[c];
    middle_row[c] = px;

    // Row 1 mirrors the bottom onto the top, column 1 the right onto the left
    if (r >= 1 && c >= 1) begin
      t = (r == 1) ? 2 : 0;
      l = (c == 1) ? 2 : 0;
      batch.push_back(window_gradient(r - 1, c - 1, t, 1, 2, l, 1, 2));
      if (on_last_row) batch.push_back(window_gradient(r, c - 1, 1, 2, 1, l, 1, 2));
      if (c == w - 1) begin
        batch.push_back(window_gradient(r - 1, c, t, 1, 2, 1, 2, 1));
        if (on_last_row) batch.push_back(window_gradient(r, c, 1, 2, 1, 1, 2, 1));
      end
    end
    for (i = 0; i < batch.size(); i++) begin
      g = batch[i];
      g.last = (i == batch.size() - 1);
      expected_gradients.push_back(g);
    end

    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    cur_row = r;
    cur_col = c;
  endtask

  task automatic check_result();
    gradient_t got;
    gradient_t want;
    got.row  = m_tdata[11:0];
    got.col  = m_tdata[21:12];
    got.gx   = m_tdata[32:22];
    got.gy   = m_tdata[43:33];
    got.ax   = m_tdata[51:44];
    got.ay   = m_tdata[59:52];
    got.mag  = m_tdata[70:60];
    got.last = m_tlast;
    if (expected_gradients.size() == 0) begin
      if (mismatches < 10) $display("unexpected result: %s", describe(got));
      mismatches++;
    end else begin
      want = expected_gradients.pop_front();
      if (got !== want) begin
        if (mismatches < 10) begin
          $display("result mismatch: expected %s", describe(want));
          $display("                 actual   %s", describe(got));
        end
        mismatches++;
      end
    end
  endtask

  // Compare outgoing items first, then fold in the incoming pixel or register write
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) win[i][j] = '0;
      end
      for (int k = 0; k < DEFAULT_MAX_WIDTH; k++) begin
        upper_row[k]  = '0;
        middle_row[k] = '0;
      end
      cur_row    = 0;
      cur_col    = 0;
      width_reg  = RESET_WIDTH;
      height_reg = RESET_HEIGHT;
      expected_gradients.delete();
    end else begin
      if (m_tvalid && m_tready) check_result();
      if (s_tvalid && s_tready) take_pixel(s_tdata);
      if (cfg_we) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:  width_reg  = cfg_data[CFG_WIDTH_W-1:0];
          REG_IMAGE_HEIGHT: height_reg = cfg_data[CFG_HEIGHT_W-1:0];
          default: ;
        endcase
        cur_row = 0;
        cur_col = 0;
      end
    end
    outstanding <= expected_gradients.size();
    fail_count  <= mismatches;
  end

endmodule
`default_nettype wire

[dv/tb.sv]
// Testbench top: clock, reset, pixel and ready stimulus, watchdog and verdict.
`default_nettype none
module tb;
  import peg_pkg::*;

  localparam int SETTLE_CYCLES = 100;
  localparam int STALL_LIMIT   = 2000;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                   s_tvalid  = 1'b0;
  logic [PIX_W-1:0]       s_tdata   = '0;
  logic                   m_tready  = 1'b0;
  logic                   steady    = 1'b0;
  wire logic              s_tready;
  wire logic              m_tvalid;
  wire logic              m_tlast;
  wire logic [TDATA_W-1:0] m_tdata;
  int                     outstanding;
  int                     fail_count;
  int                     quiet_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  prewitt_edge_gradient dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  peg_gradient_checker scoreboard (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  // Stall the result side about a quarter of the time, never during a steady phase
  always @(posedge clk) begin
    m_tready <= steady || ($urandom_range(0, 99) >= 25);
  end

  // End the run when no item or register write moves for too long
  always @(posedge clk) begin
    if (rst || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("prewitt_edge_gradient verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Mostly uniform grey levels, with black and white weighted up
  function automatic logic [PIX_W-1:0] random_pixel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Offer one pixel after a random gap and hold it until taken
  task automatic send_pixel(input logic [PIX_W-1:0] px);
    while (!steady && $urandom_range(0, 99) < 25) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= px;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Drop valid, wait for every expected result, then let the block go quiet
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_frame(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
    cfg_we    <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_frame(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                           input int count, input logic calm);
    set_frame(w, h);
    steady <= calm;
    repeat (count) send_pixel(random_pixel());
    settle();
    steady <= 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // A few pixels at the reset frame size: still row 0, so nothing comes out
    repeat (5) send_pixel(random_pixel());
    settle();

    // 3x3 frames: a dark-to-bright step across columns, then a bright top row
    set_frame(13'd3, 13'd3);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) send_pixel((c == 2) ? '1 : '0);
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) send_pixel((r == 0) ? '1 : '0);
    end
    settle();

    // Random content over several frame shapes, ending some phases mid-frame
    run_frame(13'd4, 13'd5, 17, 1'b0);
    run_frame(13'h1800, 13'd1, 10, 1'b0);
    run_frame(13'd7, 13'd4, 21, 1'b1);
    run_frame(13'd1024, 13'd3, 3, 1'b0);
    run_frame(13'd2047, 13'd8191, 3, 1'b0);
    run_frame(13'd3, 13'd4096, 9, 1'b0);
    run_frame(13'd2, 13'd2, 9, 1'b0);
    run_frame(13'd5, 13'd6, 8, 1'b0);
    run_frame(13'd3, 13'd3, 10, 1'b0);

    if (fail_count == 0 && outstanding == 0) begin
      $display("prewitt_edge_gradient verification clean");
    end else begin
      $display("prewitt_edge_gradient verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

[files.f]
sv/peg_pkg.sv
sv/peg_ram.sv
sv/peg_isqrt.sv
sv/prewitt_edge_gradient.sv
dv/peg_gradient_checker.sv
dv/tb.sv
